// ===== design/hsi_pkg.sv =====
// Shared types, constants and command codes for the hash set block.
`default_nettype none
package hsi_pkg;
	localparam int MAX_BUCKETS_DEF      = 64;
	localparam int SLOTS_PER_BUCKET_DEF = 8;
	localparam int KEY_W                = 32;
	localparam int BCNT_W               = 7;
	localparam int BIDX_W               = 6;

	localparam logic [1:0] CMD_ADD    = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_SEARCH = 2'd2;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_ABSENT = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	typedef struct packed {
		logic [1:0]       cmd;
		logic [KEY_W-1:0] key;
	} in_word_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [BIDX_W-1:0] bucket_index;
	} out_word_t;

	typedef struct packed {
		logic clr_step;
		logic start;
		logic div_step;
		logic scan_start;
		logic scan_step;
		logic commit;
	} hsi_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic div_done;
		logic scan_done;
	} hsi_sts_t;
endpackage
`default_nettype wire

// ===== design/hsi_ctrl.sv =====
// Controller state machine sequencing divide, slot scan and write-back.
`default_nettype none
module hsi_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  wire logic            out_stall,
	input  wire hsi_pkg::hsi_sts_t sts,
	output hsi_pkg::hsi_cmd_t    cmd
);
	import hsi_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV  = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_WAIT = 3'd3;
	localparam logic [2:0] S_CLR  = 3'd4;

	logic [2:0] state_q;
	logic       out_valid_q;
	logic       accept;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd            = '0;
		cmd.clr_step   = (state_q == S_CLR);
		cmd.start      = accept;
		cmd.div_step   = (state_q == S_DIV);
		cmd.scan_start = (state_q == S_DIV) && sts.div_done;
		cmd.scan_step  = (state_q == S_SCAN);
		cmd.commit     = (state_q == S_WAIT) && !out_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_CLR:  if (sts.clr_done) state_q <= S_IDLE;
				S_IDLE: if (accept) state_q <= S_DIV;
				S_DIV:  if (sts.div_done) state_q <= S_SCAN;
				S_SCAN: if (sts.scan_done) state_q <= S_WAIT;
				S_WAIT: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== design/hsi_dp.sv =====
// Datapath: restoring divider, slot memory with valid bits, scan and result.
`default_nettype none
module hsi_dp #(
	parameter int MAX_BUCKETS      = hsi_pkg::MAX_BUCKETS_DEF,
	parameter int SLOTS_PER_BUCKET = hsi_pkg::SLOTS_PER_BUCKET_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [hsi_pkg::BCNT_W-1:0] cfg_data,
	input  wire hsi_pkg::in_word_t          in_word,
	input  wire hsi_pkg::hsi_cmd_t          cmd,
	output hsi_pkg::hsi_sts_t               sts,
	output hsi_pkg::out_word_t              out_word
);
	import hsi_pkg::*;

	localparam int TOTAL  = MAX_BUCKETS * SLOTS_PER_BUCKET;
	localparam int AW     = (TOTAL > 1) ? $clog2(TOTAL) : 1;
	localparam int BW     = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
	localparam int SW     = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
	localparam int SCW    = $clog2(SLOTS_PER_BUCKET + 1);
	localparam int DCW    = $clog2(KEY_W + 1);
	localparam int MAXB_W = $clog2(MAX_BUCKETS + 1);
	localparam int RW     = (BCNT_W > MAXB_W ? BCNT_W : MAXB_W) + 1;

	logic [BCNT_W-1:0] bcnt_q;
	logic [1:0]        op_q;
	logic [KEY_W-1:0]  key_q;
	logic [KEY_W-1:0]  quo_q;
	logic [RW-1:0]     rem_q;
	logic [RW-1:0]     div_q;
	logic [DCW-1:0]    dcnt_q;
	logic [SCW-1:0]    scnt_q;
	logic [AW-1:0]     clr_q;
	logic              rd_pend_q;
	logic [SW-1:0]     rd_slot_q;
	logic [KEY_W:0]    rd_word_q;
	logic              hit_q;
	logic [SW-1:0]     hit_slot_q;
	logic              free_q;
	logic [SW-1:0]     free_slot_q;
	logic [KEY_W:0]    mem_q [TOTAL];
	out_word_t         res_q;

	logic [RW-1:0]     div_eff;
	logic [RW-1:0]     rem_sh;
	logic [BW-1:0]     bucket;
	logic [AW-1:0]     rd_addr;
	logic [AW-1:0]     hit_addr;
	logic [AW-1:0]     free_addr;
	logic              chk_v;
	logic              wr_en;
	logic              rm_en;

	always_comb begin
		div_eff = RW'(bcnt_q);
		if (bcnt_q == '0) div_eff = RW'(1);
		if (RW'(bcnt_q) > RW'(MAX_BUCKETS)) div_eff = RW'(MAX_BUCKETS);
	end

	assign rem_sh  = {rem_q[RW-2:0], quo_q[KEY_W-1]};
	assign bucket  = BW'(rem_q);
	assign rd_addr = AW'(bucket) * AW'(SLOTS_PER_BUCKET) + AW'(scnt_q[SW-1:0]);
	assign hit_addr  = AW'(bucket) * AW'(SLOTS_PER_BUCKET) + AW'(hit_slot_q);
	assign free_addr = AW'(bucket) * AW'(SLOTS_PER_BUCKET) + AW'(free_slot_q);
	assign chk_v     = rd_word_q[KEY_W];
	assign wr_en     = cmd.commit && (op_q == CMD_ADD) && free_q;
	assign rm_en     = cmd.commit && (op_q == CMD_REMOVE) && hit_q;

	assign sts.clr_done  = (clr_q == AW'(TOTAL - 1));
	assign sts.div_done  = (dcnt_q == '0);
	assign sts.scan_done = (scnt_q == SCW'(SLOTS_PER_BUCKET)) && !rd_pend_q;
	assign out_word      = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcnt_q <= BCNT_W'(64);
			dcnt_q <= '0;
			clr_q  <= '0;
		end else begin
			if (cfg_we) bcnt_q <= cfg_data;
			if (cmd.start) dcnt_q <= DCW'(KEY_W);
			else if (cmd.div_step && dcnt_q != '0) dcnt_q <= dcnt_q - 1'b1;
			if (cmd.clr_step && !sts.clr_done) clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q  <= in_word.cmd;
			key_q <= in_word.key;
			quo_q <= in_word.key;
			rem_q <= '0;
			div_q <= div_eff;
		end else if (cmd.div_step && dcnt_q != '0) begin
			quo_q <= {quo_q[KEY_W-2:0], 1'b0};
			rem_q <= (rem_sh >= div_q) ? rem_sh - div_q : rem_sh;
		end
		if (cmd.scan_start) begin
			scnt_q    <= '0;
			rd_pend_q <= 1'b0;
			hit_q     <= 1'b0;
			free_q    <= 1'b0;
		end else if (cmd.scan_step) begin
			rd_pend_q <= (scnt_q != SCW'(SLOTS_PER_BUCKET));
			if (scnt_q != SCW'(SLOTS_PER_BUCKET)) begin
				rd_word_q <= mem_q[rd_addr];
				rd_slot_q <= scnt_q[SW-1:0];
				scnt_q    <= scnt_q + 1'b1;
			end
			if (rd_pend_q) begin
				if (chk_v && rd_word_q[KEY_W-1:0] == key_q && !hit_q) begin
					hit_q      <= 1'b1;
					hit_slot_q <= rd_slot_q;
				end
				if (!chk_v && !free_q) begin
					free_q      <= 1'b1;
					free_slot_q <= rd_slot_q;
				end
			end
		end
		if (cmd.clr_step) mem_q[clr_q] <= '0;
		else if (wr_en) mem_q[free_addr] <= {1'b1, key_q};
		else if (rm_en) mem_q[hit_addr] <= {1'b0, key_q};
		if (cmd.commit) begin
			res_q.bucket_index <= BIDX_W'(rem_q);
			if (op_q == CMD_ADD) res_q.status <= free_q ? ST_OK : ST_FULL;
			else res_q.status <= hit_q ? ST_OK : ST_ABSENT;
		end
	end
endmodule
`default_nettype wire

// ===== design/hash_set_insert_remove_lookup_top.sv =====
// Top level of the division-method hash set with fixed slots per bucket.
// Input channel in_valid/in_stall carries a word of cmd and key; the
// output channel out_valid/out_stall returns status and bucket_index.
// One command is worked at a time. After the accepting edge the key
// modulo the bucket count is found by a restoring divider at one
// quotient bit a cycle, then the bucket's slots are read from the slot
// memory one per cycle, with the compare of each word and a final drain
// of the last one, then the slot is written back and the result loaded.
// in_stall stays high until the result is loaded.
// The result register holds its word while out_stall is high; the next
// command may be accepted meanwhile but will not load over it.
// After reset a clearing pass empties every slot, one per cycle, with
// in_stall high, and the bucket count is 64. cfg_we writes the bucket
// count, which is taken as 1 if zero and capped at MAX_BUCKETS.
`default_nettype none
module hash_set_insert_remove_lookup_top #(
	parameter int MAX_BUCKETS      = hsi_pkg::MAX_BUCKETS_DEF,
	parameter int SLOTS_PER_BUCKET = hsi_pkg::SLOTS_PER_BUCKET_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [hsi_pkg::BCNT_W-1:0] cfg_data,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire hsi_pkg::in_word_t          in_word,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output hsi_pkg::out_word_t              out_word
);
	import hsi_pkg::*;

	hsi_cmd_t cmd;
	hsi_sts_t sts;

	hsi_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
	);

	hsi_dp #(.MAX_BUCKETS(MAX_BUCKETS), .SLOTS_PER_BUCKET(SLOTS_PER_BUCKET)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_word(in_word), .cmd(cmd), .sts(sts), .out_word(out_word)
	);
endmodule
`default_nettype wire

// ===== design/hsi_checker.sv =====
// Port checker for the hash set top level, bound to it.
`default_nettype none
module hsi_port_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_stall,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire hsi_pkg::out_word_t out_word
);
	import hsi_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("result word changed under stall");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("word accepted back to back");
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> ##1 !$rose(out_valid))
		else $error("result too soon");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_word.status != 2'd3)
		else $error("bad status code");
endmodule

bind hash_set_insert_remove_lookup_top hsi_port_checker u_hsi_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
);
`default_nettype wire

// ===== verif/hsi_checker.sv =====
// Checker for the hash set block: watches both channels, predicts and compares results.
module hsi_checker
	import hsi_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cfg_we,
	input  wire logic [BCNT_W-1:0] cfg_data,
	input  wire logic      in_valid,
	input  wire logic      in_stall,
	input  wire in_word_t  in_word,
	input  wire logic      out_valid,
	input  wire logic      out_stall,
	input  wire out_word_t out_word,
	output int             fail_count,
	output int             pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSLOTS = MAX_BUCKETS_DEF * SLOTS_PER_BUCKET_DEF;

	logic [KEY_W-1:0] stored_key [NSLOTS];
	logic             stored_live [NSLOTS];
	logic [BCNT_W-1:0] divisor_reg;
	out_word_t        result_queue [$];

	task automatic report(input string what, input out_word_t got, input out_word_t want);
		$display("mismatch %s: got status %0d bucket %0d, want status %0d bucket %0d",
			what, got.status, got.bucket_index, want.status, want.bucket_index);
		fail_count++;
	endtask

	function automatic out_word_t hash_step(input in_word_t w);
		int unsigned d, b, s, i;
		out_word_t r;
		d = divisor_reg;
		if (d == 0) d = 1;
		if (d > MAX_BUCKETS_DEF) d = MAX_BUCKETS_DEF;
		b = w.key % d;
		r.bucket_index = b[BIDX_W-1:0];
		r.status = (w.cmd == CMD_ADD) ? ST_FULL : ST_ABSENT;
		for (s = 0; s < SLOTS_PER_BUCKET_DEF; s++) begin
			i = b * SLOTS_PER_BUCKET_DEF + s;
			if (w.cmd == CMD_ADD) begin
				if (!stored_live[i]) begin
					stored_live[i] = 1'b1;
					stored_key[i] = w.key;
					r.status = ST_OK;
					break;
				end
			end else if (stored_live[i] && stored_key[i] == w.key) begin
				if (w.cmd == CMD_REMOVE) stored_live[i] = 1'b0;
				r.status = ST_OK;
				break;
			end
		end
		return r;
	endfunction

	assign pending = result_queue.size();

	initial fail_count = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divisor_reg <= 7'd64;
			for (int i = 0; i < NSLOTS; i++) stored_live[i] = 1'b0;
		end else begin
			if (cfg_we) divisor_reg <= cfg_data;
			if (in_valid && !in_stall) result_queue.push_back(hash_step(in_word));
			if (out_valid && !out_stall) begin
				if (result_queue.size() == 0) begin
					report("unexpected word", out_word, '0);
				end else begin
					out_word_t want;
					want = result_queue.pop_front();
					if (out_word.status !== want.status) report("status", out_word, want);
					if (out_word.bucket_index !== want.bucket_index)
						report("bucket_index", out_word, want);
				end
			end
		end
	end
endmodule

// ===== verif/tb.sv =====
// Testbench top for the hash set block: stimulus, configuration phases and verdict.
module tb;
	import hsi_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk, arst_n, cfg_we, in_valid, in_stall, out_valid, out_stall;
	logic [BCNT_W-1:0] cfg_data;
	in_word_t  in_word;
	out_word_t out_word;
	int fail_count, pending;
	int unsigned cycle_count;
	bit hold_off;
	logic [KEY_W-1:0] key_pool [16];

	hash_set_insert_remove_lookup_top dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
		.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
	);

	hsi_checker chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
		.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > 400000) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	task automatic send_word(input logic [1:0] op, input logic [KEY_W-1:0] k);
		int gap;
		gap = $urandom_range(0, 4);
		repeat (gap) @(posedge clk);
		in_valid <= 1'b1;
		in_word <= '{cmd: op, key: k};
		do @(posedge clk); while (in_stall);
		in_valid <= 1'b0;
	endtask

	task automatic drain;
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_divisor(input logic [BCNT_W-1:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		for (int i = 0; i < 16; i++) key_pool[i] = $urandom_range(0, 300);
	endtask

	task automatic random_phase(input int n);
		logic [1:0] op;
		logic [KEY_W-1:0] k;
		for (int i = 0; i < n; i++) begin
			op = ($urandom_range(0, 9) < 5) ? CMD_ADD : 2'($urandom_range(1, 3));
			if ($urandom_range(0, 3) == 0) k = $urandom;
			else k = key_pool[$urandom_range(0, 15)];
			send_word(op, k);
		end
	endtask

	initial begin
		cfg_we = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_word = '0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < 16; i++) key_pool[i] = $urandom_range(0, 300);
		send_word(CMD_SEARCH, 32'd0);
		send_word(CMD_ADD, 32'd0);
		send_word(CMD_SEARCH, 32'd0);
		send_word(CMD_REMOVE, 32'd0);
		send_word(CMD_REMOVE, 32'd0);
		send_word(CMD_ADD, 32'hFFFF_FFFF);
		send_word(CMD_SEARCH, 32'hFFFF_FFFF);
		send_word(2'd3, 32'hFFFF_FFFF);
		for (int i = 0; i < 9; i++) send_word(CMD_ADD, 32'd5 + 64 * i);
		send_word(CMD_REMOVE, 32'd5);
		send_word(CMD_SEARCH, 32'd69);
		send_word(CMD_ADD, 32'hAAAA_5555);
		send_word(CMD_SEARCH, 32'h5555_AAAA);
		write_divisor(7'd0);
		send_word(CMD_ADD, 32'd12345);
		send_word(CMD_SEARCH, 32'd5);
		write_divisor(7'd127);
		send_word(CMD_SEARCH, 32'd69);
		random_phase(110);
		write_divisor(7'd1);
		random_phase(60);
		fork
			begin
				hold_off = 1'b1;
				repeat (300) @(posedge clk);
				hold_off = 1'b0;
			end
			random_phase(10);
		join
		write_divisor(7'd3);
		random_phase(110);
		write_divisor(7'd64);
		random_phase(110);
		write_divisor(7'd37);
		random_phase(120);
		drain();
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		int wait_n;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				out_stall <= 1'b1;
			end else if (out_valid && !out_stall) begin
				wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
				if (wait_n != 0) begin
					out_stall <= 1'b1;
					repeat (wait_n - 1) @(posedge clk);
				end
				out_stall <= 1'b0;
			end else if (!out_valid) begin
				out_stall <= 1'($urandom_range(0, 1));
			end else begin
				out_stall <= 1'b0;
			end
		end
	end
endmodule

// ===== hash_set_insert_remove_lookup_top.f =====
design/hsi_pkg.sv
design/hsi_ctrl.sv
design/hsi_dp.sv
design/hash_set_insert_remove_lookup_top.sv
design/hsi_checker.sv
verif/hsi_checker.sv
verif/tb.sv
